// File: rtl/hsd_pkg.sv
// Huffman stream decoder: shared constants, state encoding and the
// control/status structs between the controller and the datapath.
// No dependencies.
package hsd_pkg;

    localparam int SYM_CNT = 256;
    localparam int SYM_AW  = $clog2(SYM_CNT);
    localparam int MAX_LEN = 31;
    localparam int LEN_W   = 5;
    localparam int VAL_W   = 31;
    localparam int SYM_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 32;
    localparam int IN_DW   = 56;
    localparam int ENT_W   = LEN_W + VAL_W;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_BYTE  = 2'd3;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SHIFT = 6'b000010,
        S_SCAN  = 6'b000100,
        S_EMIT  = 6'b001000,
        S_NEXT  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    typedef struct packed {
        logic accept;
        logic shift;
        logic scan;
        logic take;
        logic emit;
        logic next_bit;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic go_decode;
        logic decided;
        logic result;
        logic out_free;
        logic p_valid;
        logic byte_done;
    } t_status;

endpackage

// File: rtl/hsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/hsd_ctrl.sv
// Huffman stream decoder controller: sequences accept, bit shift, table scan
// and result hand-off. Depends on hsd_pkg.
module hsd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  hsd_pkg::t_status i_st,
    output hsd_pkg::t_cmd    o_cmd
);

    hsd_pkg::t_state r_state;
    hsd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            hsd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_st.go_decode) begin
                        n_state = hsd_pkg::S_SHIFT;
                    end
                end
            end
            hsd_pkg::S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = hsd_pkg::S_SCAN;
            end
            hsd_pkg::S_SCAN: begin
                if (i_st.decided) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_st.result ? hsd_pkg::S_EMIT : hsd_pkg::S_NEXT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            hsd_pkg::S_EMIT: begin
                if (!i_st.p_valid || i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = hsd_pkg::S_NEXT;
                end
            end
            hsd_pkg::S_NEXT: begin
                if (i_st.byte_done) begin
                    n_state = hsd_pkg::S_DONE;
                end else begin
                    o_cmd.next_bit = 1'b1;
                    n_state        = hsd_pkg::S_SHIFT;
                end
            end
            hsd_pkg::S_DONE: begin
                if (!i_st.p_valid) begin
                    n_state = hsd_pkg::S_IDLE;
                end else if (i_st.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = hsd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hsd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/hsd_dp.sv
// Huffman stream decoder datapath: code table, frame state, accumulator,
// scan match, pending result and output register. Depends on hsd_pkg, hsd_ram.
module hsd_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_opcode,
    input  logic [hsd_pkg::SYM_W-1:0]   i_symbol,
    input  logic [hsd_pkg::LEN_W-1:0]   i_code_length,
    input  logic [hsd_pkg::VAL_W-1:0]   i_code_value,
    input  logic [hsd_pkg::BYTE_W-1:0]  i_data_byte,
    input  hsd_pkg::t_cmd               i_cmd,
    output hsd_pkg::t_status            o_st,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [hsd_pkg::SYM_W-1:0]   o_out_symbol,
    output logic                        o_out_last,
    output logic                        o_out_end,
    output logic                        o_out_err
);

    logic [hsd_pkg::SYM_CNT-1:0] r_valid;
    logic                        r_active;
    logic [2:0]                  r_hdr;
    logic [hsd_pkg::CNT_W-1:0]   r_rem;
    logic [hsd_pkg::VAL_W-1:0]   r_acc;
    logic [hsd_pkg::LEN_W-1:0]   r_nbits;
    logic [2:0]                  r_bidx;
    logic [hsd_pkg::BYTE_W-1:0]  r_byte;
    logic [hsd_pkg::SYM_AW-1:0]  r_addr;
    logic [hsd_pkg::SYM_AW-1:0]  r_addr_q;
    logic                        r_rd_vld;
    logic                        r_nv;
    logic [hsd_pkg::SYM_W-1:0]   r_nsym;
    logic                        r_nend;
    logic                        r_nerr;
    logic                        r_pv;
    logic [hsd_pkg::SYM_W-1:0]   r_psym;
    logic                        r_pend;
    logic                        r_perr;
    logic                        r_mv;
    logic [hsd_pkg::SYM_W-1:0]   r_msym;
    logic                        r_mlast;
    logic                        r_mend;
    logic                        r_merr;

    logic                        wr_en;
    logic                        sym_ok;
    logic [hsd_pkg::ENT_W-1:0]   rd_ent;
    logic [hsd_pkg::LEN_W-1:0]   rd_len;
    logic [hsd_pkg::VAL_W-1:0]   rd_val;
    logic [hsd_pkg::VAL_W-1:0]   mask;
    logic                        hit;
    logic                        miss;
    logic                        too_long;
    logic                        out_free;
    logic                        push;

    assign sym_ok = ({1'b0, i_symbol} < (hsd_pkg::SYM_W + 1)'(hsd_pkg::SYM_CNT));
    assign wr_en  = i_cmd.accept && (i_opcode == hsd_pkg::OP_LOAD) && sym_ok;

    hsd_ram #(
        .WIDTH(hsd_pkg::ENT_W),
        .DEPTH(hsd_pkg::SYM_CNT)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(i_symbol[hsd_pkg::SYM_AW-1:0]),
        .i_wdata({i_code_length, i_code_value}),
        .i_raddr(r_addr),
        .o_rdata(rd_ent)
    );

    assign rd_len   = rd_ent[hsd_pkg::ENT_W-1 -: hsd_pkg::LEN_W];
    assign rd_val   = rd_ent[hsd_pkg::VAL_W-1:0];
    assign mask     = ~({hsd_pkg::VAL_W{1'b1}} << rd_len);
    assign hit      = r_rd_vld && r_valid[r_addr_q] && (rd_len != '0)
                      && (rd_len == r_nbits)
                      && ({1'b0, rd_len} <= (hsd_pkg::LEN_W + 1)'(hsd_pkg::MAX_LEN))
                      && ((rd_val & mask) == r_acc);
    assign miss     = r_rd_vld && !hit
                      && (r_addr_q == hsd_pkg::SYM_AW'(hsd_pkg::SYM_CNT - 1));
    assign too_long = ({1'b0, r_nbits} >= (hsd_pkg::LEN_W + 1)'(hsd_pkg::MAX_LEN));
    assign out_free = !r_mv || i_out_ready;
    assign push     = (i_cmd.emit && r_pv) || i_cmd.flush;

    always_comb begin
        o_st.go_decode = (i_opcode == hsd_pkg::OP_BYTE) && r_active && (r_hdr == 3'd4);
        o_st.decided   = hit || miss;
        o_st.result    = hit || too_long;
        o_st.out_free  = out_free;
        o_st.p_valid   = r_pv;
        o_st.byte_done = (r_bidx == 3'd7) || !r_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_active <= 1'b0;
            r_hdr    <= '0;
            r_rem    <= '0;
            r_acc    <= '0;
            r_nbits  <= '0;
            r_rd_vld <= 1'b0;
            r_pv     <= 1'b0;
            r_mv     <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                case (i_opcode)
                    hsd_pkg::OP_CLEAR: begin
                        r_valid <= '0;
                    end
                    hsd_pkg::OP_LOAD: begin
                        if (sym_ok) begin
                            r_valid[i_symbol[hsd_pkg::SYM_AW-1:0]] <= 1'b1;
                        end
                    end
                    hsd_pkg::OP_START: begin
                        r_active <= 1'b1;
                        r_hdr    <= '0;
                        r_rem    <= '0;
                        r_acc    <= '0;
                        r_nbits  <= '0;
                    end
                    hsd_pkg::OP_BYTE: begin
                        if (r_active && r_hdr != 3'd4) begin
                            r_rem[{r_hdr[1:0], 3'b000} +: 8] <= i_data_byte;
                            r_hdr <= r_hdr + 3'd1;
                            if (r_hdr == 3'd3 && i_data_byte == '0 && r_rem[23:0] == '0) begin
                                r_active <= 1'b0;
                            end
                        end
                    end
                    default: begin
                        r_active <= r_active;
                    end
                endcase
            end
            if (i_cmd.shift) begin
                r_acc    <= {r_acc[hsd_pkg::VAL_W-2:0], r_byte[r_bidx]};
                r_nbits  <= r_nbits + 5'd1;
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_rd_vld <= 1'b1;
            end
            if (i_cmd.take) begin
                r_rd_vld <= 1'b0;
                if (hit) begin
                    r_rem   <= r_rem - 32'd1;
                    r_acc   <= '0;
                    r_nbits <= '0;
                    if (r_rem == 32'd1) begin
                        r_active <= 1'b0;
                    end
                end else if (too_long) begin
                    r_active <= 1'b0;
                    r_acc    <= '0;
                    r_nbits  <= '0;
                end
            end
            if (i_cmd.emit) begin
                r_pv <= r_nv;
            end else if (i_cmd.flush) begin
                r_pv <= 1'b0;
            end
            if (push) begin
                r_mv <= 1'b1;
            end else if (i_out_ready) begin
                r_mv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_data_byte;
            r_bidx <= '0;
        end
        if (i_cmd.next_bit) begin
            r_bidx <= r_bidx + 3'd1;
        end
        if (i_cmd.shift) begin
            r_addr <= '0;
        end
        if (i_cmd.scan) begin
            r_addr   <= r_addr + hsd_pkg::SYM_AW'(1);
            r_addr_q <= r_addr;
        end
        if (i_cmd.take) begin
            r_nv   <= hit || too_long;
            r_nsym <= hit ? hsd_pkg::SYM_W'(r_addr_q) : '0;
            r_nend <= hit && (r_rem == 32'd1);
            r_nerr <= !hit;
        end
        if (i_cmd.emit) begin
            r_psym <= r_nsym;
            r_pend <= r_nend;
            r_perr <= r_nerr;
        end
        if (push) begin
            r_msym  <= r_psym;
            r_mlast <= i_cmd.flush;
            r_mend  <= r_pend;
            r_merr  <= r_perr;
        end
    end

    assign o_out_valid  = r_mv;
    assign o_out_symbol = r_msym;
    assign o_out_last   = r_mlast;
    assign o_out_end    = r_mend;
    assign o_out_err    = r_merr;

endmodule

// File: rtl/huffman_stream_decoder_core.sv
// Huffman stream decoder top level: stream ports, controller and datapath.
// Depends on hsd_pkg, hsd_ctrl, hsd_dp, hsd_ram.
//
// channel   dir  tdata                          tuser                  tlast
// s_axis    in   symbol,code_length,code_value, opcode                 -
//                data_byte
// m_axis    out  decoded_symbol                 frame_end,error        last
//
// Table, start and header items complete on acceptance. A payload byte takes, per bit,
// a shift step, a scan of the code table RAM ending at the first match or the
// last entry, an emit step when a result is due and a next-bit step.
// Reset clears table valid bits and frame state. A full output register stalls
// the decoder; the input is not taken until the byte is finished.
module huffman_stream_decoder_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [hsd_pkg::IN_DW-1:0]   s_axis_tdata,  // symbol, code_length, code_value, data_byte
    input  logic [1:0]                  s_axis_tuser,  // opcode
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [hsd_pkg::SYM_W-1:0]   m_axis_tdata,  // decoded_symbol
    output logic [1:0]                  m_axis_tuser,  // frame_end, error
    output logic                        m_axis_tlast
);

    hsd_pkg::t_cmd    cmd;
    hsd_pkg::t_status st;
    logic             end_flag;
    logic             err_flag;

    hsd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_st      (st),
        .o_cmd     (cmd)
    );

    hsd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_opcode     (s_axis_tuser),
        .i_symbol     (s_axis_tdata[7:0]),
        .i_code_length(s_axis_tdata[12:8]),
        .i_code_value (s_axis_tdata[43:13]),
        .i_data_byte  (s_axis_tdata[51:44]),
        .i_cmd        (cmd),
        .o_st         (st),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_symbol (m_axis_tdata),
        .o_out_last   (m_axis_tlast),
        .o_out_end    (end_flag),
        .o_out_err    (err_flag)
    );

    assign m_axis_tuser = {err_flag, end_flag};

endmodule

// File: tb/huffman_stream_decoder_core_chk.sv
// Checker for the Huffman stream decoder: watches both stream channels,
// predicts the decoded symbols of every input item and compares results.
// Depends on hsd_pkg.
module huffman_stream_decoder_core_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [hsd_pkg::IN_DW-1:0]   i_s_tdata,  // symbol, code_length, code_value, data_byte
    input  logic [1:0]                  i_s_tuser,  // opcode
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [hsd_pkg::SYM_W-1:0]   i_m_tdata,  // decoded_symbol
    input  logic [1:0]                  i_m_tuser,  // frame_end, error
    input  logic                        i_m_tlast,
    output int                          o_errors,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import hsd_pkg::*;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             fend;
        logic             err;
    } t_sym_res;

    logic [LEN_W-1:0] len_tab [SYM_CNT];
    logic [VAL_W-1:0] val_tab [SYM_CNT];
    logic [VAL_W-1:0] acc;
    logic [LEN_W-1:0] nbits;
    int               hdr_seen;
    logic [CNT_W-1:0] remaining;
    logic             active;
    t_sym_res         exp_syms [$];

    function automatic int find_symbol();
        logic [31:0] mask;
        for (int s = 0; s < SYM_CNT; s++) begin
            mask = (32'd1 << len_tab[s]) - 32'd1;
            if (len_tab[s] != 0 && len_tab[s] == nbits &&
                ((32'(val_tab[s]) & mask) == 32'(acc)))
                return s;
        end
        return -1;
    endfunction

    task automatic decode_item(input logic [1:0] op, input logic [7:0] sym,
                               input logic [4:0] clen, input logic [30:0] cval,
                               input logic [7:0] dbyte);
        int n;
        int m;
        t_sym_res r;
        n = 0;
        case (op)
            OP_CLEAR: foreach (len_tab[i]) len_tab[i] = '0;
            OP_LOAD: begin
                len_tab[sym] = clen;
                val_tab[sym] = cval;
            end
            OP_START: begin
                active = 1'b1;
                hdr_seen = 0;
                remaining = '0;
                acc = '0;
                nbits = '0;
            end
            default: begin
                if (active && hdr_seen < 4) begin
                    remaining |= 32'(dbyte) << (8 * hdr_seen);
                    hdr_seen++;
                    if (hdr_seen == 4 && remaining == 0)
                        active = 1'b0;
                end else if (active) begin
                    for (int b = 0; b < 8 && active; b++) begin
                        acc = {acc[VAL_W-2:0], dbyte[b]};
                        nbits = nbits + 5'd1;
                        m = find_symbol();
                        if (m >= 0) begin
                            remaining--;
                            acc = '0;
                            nbits = '0;
                            r = '{sym: m[7:0], last: 1'b0, fend: (remaining == 0), err: 1'b0};
                            if (remaining == 0)
                                active = 1'b0;
                            exp_syms.push_back(r);
                            n++;
                        end else if (nbits >= MAX_LEN) begin
                            active = 1'b0;
                            acc = '0;
                            nbits = '0;
                            exp_syms.push_back('{sym: '0, last: 1'b0, fend: 1'b0, err: 1'b1});
                            n++;
                        end
                    end
                    if (n > 0)
                        exp_syms[$].last = 1'b1;
                end
            end
        endcase
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_sym_res e;
        if (!i_rst_n) begin
            foreach (len_tab[i]) begin
                len_tab[i] = '0;
                val_tab[i] = '0;
            end
            acc = '0;
            nbits = '0;
            hdr_seen = 0;
            remaining = '0;
            active = 1'b0;
            exp_syms.delete();
            o_errors = 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                decode_item(i_s_tuser, i_s_tdata[7:0], i_s_tdata[12:8],
                            i_s_tdata[43:13], i_s_tdata[51:44]);
            if (i_m_tvalid && i_m_tready) begin
                if (exp_syms.size() == 0) begin
                    report("unexpected item", i_m_tdata, 0);
                end else begin
                    e = exp_syms.pop_front();
                    if (i_m_tdata !== e.sym)     report("decoded_symbol", i_m_tdata, e.sym);
                    if (i_m_tlast !== e.last)    report("last", i_m_tlast, e.last);
                    if (i_m_tuser[0] !== e.fend) report("frame_end", i_m_tuser[0], e.fend);
                    if (i_m_tuser[1] !== e.err)  report("error", i_m_tuser[1], e.err);
                end
            end
        end
        o_pending = exp_syms.size();
    end

endmodule

// File: tb/huffman_stream_decoder_core_tb.sv
// Testbench top for the Huffman stream decoder: drives table loads and
// coded frames with random idling and stalls, and gives the verdict.
// Depends on hsd_pkg, huffman_stream_decoder_core, huffman_stream_decoder_core_chk.
module huffman_stream_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hsd_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int TAIL_CYCLES = 2200;
    localparam int ITEM_TARGET = 420;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_DW-1:0]    s_axis_tdata;
    logic [1:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [SYM_W-1:0]    m_axis_tdata;
    logic [1:0]          m_axis_tuser;
    logic                m_axis_tlast;
    int                  errors;
    int                  pending;

    int                  sent;
    int                  idle_cnt = 0;
    logic                quiet;
    logic                choke_req;
    logic                choke_done = 1'b0;
    int                  hold = 0;
    int                  stall_pct;

    logic [7:0]          ids [8];
    logic [4:0]          cl [8];
    logic [30:0]         cv [8];
    int                  nsym;

    always #6 i_clk = ~i_clk;

    huffman_stream_decoder_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    huffman_stream_decoder_core_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tuser(m_axis_tuser),
        .i_m_tlast(m_axis_tlast),
        .o_errors(errors), .o_pending(pending)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 70);
    endfunction

    task automatic send(input logic [1:0] op, input logic [7:0] sym, input logic [4:0] clen,
                        input logic [30:0] cval, input logic [7:0] dbyte);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, dbyte, cval, clen, sym};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_byte(input logic [7:0] dbyte);
        send(OP_BYTE, 8'($urandom), 5'($urandom), 31'($urandom), dbyte);
    endtask

    task automatic send_count(input logic [31:0] cnt);
        for (int i = 0; i < 4; i++) send_byte(cnt[8*i +: 8]);
    endtask

    task automatic load_table(input int kind);
        int base;
        int k;
        logic [30:0] v;
        send(OP_CLEAR, 8'($urandom), 5'($urandom), 31'($urandom), 8'($urandom));
        base = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 255);
        case (kind)
            0: begin
                nsym = $urandom_range(2, 8);
                for (int i = 0; i < nsym; i++) begin
                    cl[i] = (i == nsym - 1) ? 5'(i) : 5'(i + 1);
                    cv[i] = (i == nsym - 1) ? (31'd1 << i) - 31'd1
                                            : ((31'd1 << i) - 31'd1) << 1;
                end
            end
            1: begin
                k = $urandom_range(1, 3);
                nsym = 1 << k;
                for (int i = 0; i < nsym; i++) begin
                    cl[i] = 5'(k);
                    cv[i] = 31'(i);
                end
            end
            default: begin
                nsym = $urandom_range(2, 6);
                for (int i = 0; i < nsym; i++) begin
                    cl[i] = 5'($urandom_range(1, 31));
                    cv[i] = 31'($urandom) & ((31'd1 << cl[i]) - 31'd1);
                end
            end
        endcase
        for (int i = 0; i < nsym; i++) begin
            ids[i] = 8'(base + i);
            v = cv[i];
            if ($urandom_range(0, 1) && cl[i] < 31)
                v = v | (31'($urandom) << cl[i]);
            send(OP_LOAD, ids[i], cl[i], v, 8'($urandom));
        end
    endtask

    task automatic send_frame();
        logic bitq [$];
        int n;
        int s;
        int nbytes;
        int idx;
        logic [7:0] d;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
            s = $urandom_range(0, nsym - 1);
            for (int b = cl[s] - 1; b >= 0; b--) bitq.push_back(cv[s][b]);
        end
        nbytes = (bitq.size() + 7) / 8;
        if ($urandom_range(0, 9) == 0 && nbytes > 1) nbytes = $urandom_range(1, nbytes - 1);
        send(OP_START, 8'($urandom), 5'($urandom), 31'($urandom), 8'($urandom));
        if ($urandom_range(0, 19) == 0) send_count($urandom);
        else send_count(n);
        for (int j = 0; j < nbytes; j++) begin
            for (int b = 0; b < 8; b++) begin
                idx = j * 8 + b;
                d[b] = (idx < bitq.size()) ? bitq[idx] : 1'($urandom);
            end
            send_byte(d);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold > 0) begin
            m_axis_tready <= 1'b0;
            hold = hold - 1;
        end else if (choke_req && !choke_done) begin
            m_axis_tready <= 1'b0;
            choke_done = 1'b1;
            hold = 600;
        end else if ($urandom_range(0, 199) == 0) begin
            m_axis_tready <= 1'b0;
            hold = $urandom_range(20, 60);
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_CLEAR;
        sent = 0;
        quiet = 1'b0;
        choke_req = 1'b0;
        stall_pct = 20;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'hA5);
        send(OP_LOAD, 8'd255, 5'd31, 31'h7FFF_FFFF, 8'h00);
        send(OP_LOAD, 8'd0, 5'd1, 31'h7FFF_FFFE, 8'hFF);
        send(OP_LOAD, 8'd1, 5'd2, 31'h5555_5556, 8'h00);
        send(OP_LOAD, 8'd3, 5'd2, 31'h0000_0002, 8'h00);
        send(OP_LOAD, 8'd2, 5'd0, 31'h2AAA_AAAA, 8'h00);
        send(OP_START, 8'h00, 5'd0, 31'd0, 8'h00);
        send_count(32'd0);
        send_byte(8'h3C);
        send(OP_START, 8'hFF, 5'd31, 31'h7FFF_FFFF, 8'hFF);
        send_count(32'd3);
        send_byte(8'hF2);
        send(OP_START, 8'h00, 5'd0, 31'd0, 8'h00);
        send_byte(8'd5);
        send(OP_START, 8'h00, 5'd0, 31'd0, 8'h00);
        send_count(32'd1);
        repeat (4) send_byte(8'hFF);
        send(OP_CLEAR, 8'hFF, 5'd31, 31'h7FFF_FFFF, 8'hFF);
        send(OP_START, 8'h00, 5'd0, 31'd0, 8'h00);
        send_count(32'hFFFF_FFFF);
        repeat (4) send_byte(8'h00);

        load_table(0);
        while (sent < ITEM_TARGET) begin
            quiet = ($urandom_range(0, 5) == 0);
            stall_pct = $urandom_range(0, 3) * 15;
            if (sent > 120 && !choke_req) choke_req = 1'b1;
            if (sent > 260 && sent < 280) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) < 2) load_table($urandom_range(0, 9) < 8 ? $urandom_range(0, 1) : 2);
            if ($urandom_range(0, 19) == 0)
                send(2'($urandom), 8'($urandom), 5'($urandom), 31'($urandom), 8'($urandom));
            send_frame();
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
